// ===== rtl/haptic_layer_mixer_unit_defines.svh =====
`ifndef HAPTIC_LAYER_MIXER_UNIT_DEFINES_SVH
`define HAPTIC_LAYER_MIXER_UNIT_DEFINES_SVH

// implication check on clk, off while arst_n is low
`define HLM_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("haptic layer mixer check failed");

// invariant check on clk
`define HLM_ASSERT_ALWAYS(label, cond) \
	`HLM_ASSERT_IMPLY(label, 1'b1, cond)

`endif

// ===== rtl/hlm_pkg.sv =====
package hlm_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL1,
		ST_MUL2,
		ST_WRITE,
		ST_SUM,
		ST_FIN
	} state_t;

	localparam logic [1:0] MODE_PLAY = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;

	localparam logic [1:0] SIDE_LEFT  = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;

	// floor(x / 65025) as (x * 1032) >> 26, then one correction step
	localparam logic [15:0] DIV_K    = 16'd65025;
	localparam logic [10:0] RECIP_K  = 11'd1032;
	localparam int          RECIP_SH = 26;

	typedef struct packed {
		logic latch;
		logic res_clr;
		logic set_valid;
		logic tick_upd;
		logic stop;
		logic sum_step;
		logic play_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       reject;
		logic       empty;
		logic       sum_last;
		logic       out_busy;
	} sts_t;

endpackage

// ===== rtl/hlm_ctrl.sv =====
module hlm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hlm_pkg::sts_t sts,
	output hlm_pkg::cmd_t cmd
);

	hlm_pkg::state_t state_q;
	hlm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hlm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			hlm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = hlm_pkg::ST_DECODE;
				end
			end
			hlm_pkg::ST_DECODE: begin
				cmd.res_clr = 1'b1;
				case (sts.mode)
					hlm_pkg::MODE_PLAY: begin
						state_d = sts.reject ? hlm_pkg::ST_FIN : hlm_pkg::ST_MUL1;
					end
					hlm_pkg::MODE_TICK: begin
						if (sts.empty) begin
							state_d = hlm_pkg::ST_FIN;
						end else begin
							cmd.set_valid = 1'b1;
							cmd.tick_upd  = 1'b1;
							state_d       = hlm_pkg::ST_SUM;
						end
					end
					hlm_pkg::MODE_STOP: begin
						cmd.set_valid = 1'b1;
						cmd.stop      = 1'b1;
						state_d       = hlm_pkg::ST_FIN;
					end
					default: begin
						state_d = hlm_pkg::ST_FIN;
					end
				endcase
			end
			hlm_pkg::ST_MUL1: begin
				state_d = hlm_pkg::ST_MUL2;
			end
			hlm_pkg::ST_MUL2: begin
				state_d = hlm_pkg::ST_WRITE;
			end
			hlm_pkg::ST_WRITE: begin
				cmd.play_wr = 1'b1;
				state_d     = hlm_pkg::ST_FIN;
			end
			hlm_pkg::ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_last) begin
					state_d = hlm_pkg::ST_FIN;
				end
			end
			hlm_pkg::ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = hlm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hlm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/hlm_datapath.sv =====
`include "haptic_layer_mixer_unit_defines.svh"

module hlm_datapath #(
	parameter int MAX_LAYERS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic [63:0]   in_data,
	input  logic [1:0]    in_user,
	input  hlm_pkg::cmd_t cmd,
	output hlm_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [39:0]   out_data,
	output logic          out_user
);

	localparam int IW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int CW = $clog2(MAX_LAYERS + 1);

	logic [1:0]  mode_q;
	logic [1:0]  target_q;
	logic [15:0] dur_q;
	logic [7:0]  la_q;
	logic [7:0]  sa_q;
	logic [7:0]  inten_q;
	logic [15:0] tick_q;
	logic [7:0]  gs_q;

	logic [MAX_LAYERS-1:0] live_q;
	logic [1:0]            side_q   [MAX_LAYERS];
	logic [15:0]           rem_q    [MAX_LAYERS];
	logic [7:0]            large_q  [MAX_LAYERS];
	logic [7:0]            small_q  [MAX_LAYERS];
	logic [CW-1:0]         cnt_q;
	logic [CW+3:0]         cnt_ext;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         free_c;
	logic [IW-1:0]         free_q;

	logic [15:0] g_s1;
	logic [23:0] xl_s2;
	logic [23:0] xs_s2;
	logic [34:0] pl;
	logic [34:0] ps;
	logic [7:0]  ql_s3;
	logic [7:0]  qs_s3;

	logic [7:0] ll_q;
	logic [7:0] ls_q;
	logic [7:0] rl_q;
	logic [7:0] rs_q;
	logic       valid_q;
	logic       acc_q;
	logic       sum_hit;

	logic        out_valid_q;
	logic [39:0] od_q;
	logic        ou_q;

	function automatic logic [7:0] div_fix(input logic [23:0] x, input logic [7:0] q0);
		logic [23:0] r;
		r = x - 24'(q0) * 24'(hlm_pkg::DIV_K);
		return (r >= 24'(hlm_pkg::DIV_K)) ? q0 + 8'd1 : q0;
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q   <= in_user;
			target_q <= in_data[1:0];
			dur_q    <= in_data[17:2];
			la_q     <= in_data[25:18];
			sa_q     <= in_data[33:26];
			inten_q  <= in_data[41:34];
			tick_q   <= in_data[57:42];
		end
	end

	// scaling pipeline runs freely; the controller waits for it
	assign pl = 35'(xl_s2) * 35'(hlm_pkg::RECIP_K);
	assign ps = 35'(xs_s2) * 35'(hlm_pkg::RECIP_K);

	always_ff @(posedge clk) begin
		g_s1  <= 16'(gs_q) * 16'(inten_q);
		xl_s2 <= 24'(la_q) * 24'(g_s1);
		xs_s2 <= 24'(sa_q) * 24'(g_s1);
		ql_s3 <= pl[hlm_pkg::RECIP_SH +: 8];
		qs_s3 <= ps[hlm_pkg::RECIP_SH +: 8];
	end

	always_comb begin
		free_c = '0;
		for (int k = MAX_LAYERS - 1; k >= 0; k--) begin
			if (!live_q[k]) begin
				free_c = IW'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		free_q <= free_c;
	end

	assign sum_hit = cmd.sum_step && live_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q   <= 8'hFF;
			live_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				gs_q <= cfg_wdata;
				if (cfg_wdata == 8'd0) begin
					live_q <= '0;
					cnt_q  <= '0;
				end
			end
			if (cmd.stop) begin
				live_q <= '0;
				cnt_q  <= '0;
			end
			if (cmd.play_wr) begin
				live_q[free_q] <= 1'b1;
				cnt_q          <= cnt_q + CW'(1);
			end
			if (cmd.tick_upd) begin
				for (int k = 0; k < MAX_LAYERS; k++) begin
					if (live_q[k] && (rem_q[k] <= tick_q)) begin
						live_q[k] <= 1'b0;
					end
				end
				cnt_q <= '0;
				idx_q <= '0;
			end
			if (cmd.sum_step) begin
				idx_q <= idx_q + IW'(1);
			end
			if (sum_hit) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.play_wr) begin
			side_q[free_q]  <= target_q;
			rem_q[free_q]   <= dur_q;
			large_q[free_q] <= div_fix(xl_s2, ql_s3);
			small_q[free_q] <= div_fix(xs_s2, qs_s3);
		end
		if (cmd.tick_upd) begin
			for (int k = 0; k < MAX_LAYERS; k++) begin
				if (live_q[k] && (rem_q[k] > tick_q)) begin
					rem_q[k] <= rem_q[k] - tick_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_clr) begin
			ll_q    <= 8'd0;
			ls_q    <= 8'd0;
			rl_q    <= 8'd0;
			rs_q    <= 8'd0;
			acc_q   <= 1'b0;
			valid_q <= cmd.set_valid;
		end
		if (cmd.play_wr) begin
			acc_q <= 1'b1;
		end
		if (sum_hit) begin
			if (side_q[idx_q] != hlm_pkg::SIDE_RIGHT) begin
				ll_q <= sat_add(ll_q, large_q[idx_q]);
				ls_q <= sat_add(ls_q, small_q[idx_q]);
			end
			if (side_q[idx_q] != hlm_pkg::SIDE_LEFT) begin
				rl_q <= sat_add(rl_q, large_q[idx_q]);
				rs_q <= sat_add(rs_q, small_q[idx_q]);
			end
		end
	end

	assign cnt_ext = {4'd0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			od_q <= {2'd0, (cnt_q != '0), cnt_ext[3:0], acc_q, rs_q, rl_q, ls_q, ll_q};
			ou_q <= valid_q;
		end
	end

	assign sts.mode     = mode_q;
	assign sts.reject   = (cnt_q == CW'(MAX_LAYERS)) || (gs_q == 8'd0);
	assign sts.empty    = (cnt_q == '0);
	assign sts.sum_last = (idx_q == IW'(MAX_LAYERS - 1));
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = od_q;
	assign out_user  = ou_q;

	`HLM_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(MAX_LAYERS))
	`HLM_ASSERT_IMPLY(a_wr_free_slot, cmd.play_wr, !live_q[free_q])
	`HLM_ASSERT_IMPLY(a_load_when_free, cmd.load_out, !out_valid_q || out_ready)
	`HLM_ASSERT_IMPLY(a_quiet_levels, out_valid_q && !ou_q, od_q[31:0] == 32'd0)

endmodule

// ===== rtl/haptic_layer_mixer_unit.sv =====
// A play beat is decoded, scaled through the g_s1, xl_s2 and ql_s3 registers and written
// to a free slot; a tick on a live table sums one slot per cycle; stop, a rejected play
// or an empty tick go straight to the result beat. No new beat is taken until the result
// beat is loaded, and a stalled result beat holds the block.
// Reset: arst_n clears all layers, sets global scale to 255 and empties the output register.
module haptic_layer_mixer_unit #(
	parameter int MAX_LAYERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,    // global_scale
	input  logic        s_tvalid,
	output logic        s_tready,
	// target[1:0], duration_ms[17:2], large_amplitude[25:18], small_amplitude[33:26],
	// intensity[41:34], tick_ms[57:42], zero[63:58]
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,      // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_large[7:0], left_small[15:8], right_large[23:16], right_small[31:24],
	// accepted[32], active_count[36:33], rumbling[37], zero[39:38]
	output logic [39:0] m_tdata,
	output logic        m_tuser       // motors_valid
);

	hlm_pkg::cmd_t cmd;
	hlm_pkg::sts_t sts;

	hlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hlm_datapath #(
		.MAX_LAYERS (MAX_LAYERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
